[hw/rtl/rld_pkg.sv]
package rld_pkg;

    localparam int unsigned LENGTH_WIDTH_DEF = 24;
    localparam int unsigned CFG_WIDTH        = 24;
    localparam int unsigned BYTE_WIDTH       = 8;
    localparam int unsigned KIND_WIDTH       = 2;
    localparam int unsigned COUNT_WIDTH      = 15;
    localparam int unsigned STATUS_WIDTH     = 2;
    localparam int unsigned OUT_TDATA_WIDTH  = 16;

    typedef enum logic [KIND_WIDTH-1:0] {
        KIND_BYTE = 2'd0,
        KIND_TICK = 2'd1,
        KIND_END  = 2'd2,
        KIND_NOP  = 2'd3
    } t_kind;

    typedef enum logic [STATUS_WIDTH-1:0] {
        ST_NONE         = 2'd0,
        ST_ZERO_LITERAL = 2'd1,
        ST_TOO_LONG     = 2'd2,
        ST_EARLY_END    = 2'd3
    } t_status;

    typedef struct packed {
        logic                    out_valid;
        logic [BYTE_WIDTH-1:0]   out_byte;
        logic                    byte_taken;
        logic                    done_res;
        t_status                 error_code;
    } t_result;

endpackage

[hw/rtl/rld_core.sv]
module rld_core #(
    parameter int unsigned LENGTH_WIDTH = rld_pkg::LENGTH_WIDTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_wr_en,
    input  logic [rld_pkg::CFG_WIDTH-1:0]     i_cfg_wr_data,
    input  logic                              i_step,
    input  rld_pkg::t_kind                    i_kind,
    input  logic [rld_pkg::BYTE_WIDTH-1:0]    i_byte,
    output rld_pkg::t_result                  o_result
);
    import rld_pkg::*;

    typedef enum logic [2:0] {
        PH_TAG_LO   = 3'd0,
        PH_TAG_HI   = 3'd1,
        PH_RUN_CHAR = 3'd2,
        PH_RUN_EMIT = 3'd3,
        PH_LITERAL  = 3'd4
    } t_phase;

    t_phase                  r_phase, n_phase;
    logic [BYTE_WIDTH-1:0]   r_tag_lo, n_tag_lo;
    logic [COUNT_WIDTH-1:0]  r_packet_count, n_packet_count;
    logic [BYTE_WIDTH-1:0]   r_run_char, n_run_char;
    logic [LENGTH_WIDTH-1:0] r_remaining, n_remaining;
    t_status                 r_status, n_status;

    logic                    w_idle;
    logic [COUNT_WIDTH-1:0]  w_count;
    logic [COUNT_WIDTH-1:0]  w_count_dec;
    logic                    w_valid;
    logic [BYTE_WIDTH-1:0]   w_obyte;
    logic                    w_taken;

    assign w_idle      = (r_status != ST_NONE) ||
                         (r_phase == PH_TAG_LO && r_remaining == '0);
    assign w_count     = {i_byte[BYTE_WIDTH-2:0], r_tag_lo};
    assign w_count_dec = r_packet_count - COUNT_WIDTH'(1);

    always_comb begin
        n_phase        = r_phase;
        n_tag_lo       = r_tag_lo;
        n_packet_count = r_packet_count;
        n_run_char     = r_run_char;
        n_remaining    = r_remaining;
        n_status       = r_status;
        w_valid        = 1'b0;
        w_obyte        = '0;
        w_taken        = 1'b0;
        if (!w_idle) begin
            case (i_kind)
                KIND_BYTE: begin
                    case (r_phase)
                        PH_TAG_LO: begin
                            n_tag_lo = i_byte;
                            n_phase  = PH_TAG_HI;
                            w_taken  = 1'b1;
                        end
                        PH_TAG_HI: begin
                            w_taken = 1'b1;
                            if (LENGTH_WIDTH'(w_count) > r_remaining) begin
                                n_status = ST_TOO_LONG;
                            end else if (i_byte[BYTE_WIDTH-1]) begin
                                n_packet_count = w_count;
                                n_phase        = PH_RUN_CHAR;
                            end else if (w_count == '0) begin
                                n_status = ST_ZERO_LITERAL;
                            end else begin
                                n_packet_count = w_count;
                                n_phase        = PH_LITERAL;
                            end
                        end
                        PH_RUN_CHAR: begin
                            n_run_char = i_byte;
                            w_taken    = 1'b1;
                            n_phase    = (r_packet_count == '0) ? PH_TAG_LO : PH_RUN_EMIT;
                        end
                        PH_LITERAL: begin
                            w_taken        = 1'b1;
                            w_valid        = 1'b1;
                            w_obyte        = i_byte;
                            n_remaining    = r_remaining - LENGTH_WIDTH'(1);
                            n_packet_count = w_count_dec;
                            if (w_count_dec == '0) begin
                                n_phase = PH_TAG_LO;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                KIND_TICK: begin
                    if (r_phase == PH_RUN_EMIT) begin
                        w_valid        = 1'b1;
                        w_obyte        = r_run_char;
                        n_remaining    = r_remaining - LENGTH_WIDTH'(1);
                        n_packet_count = w_count_dec;
                        if (w_count_dec == '0) begin
                            n_phase = PH_TAG_LO;
                        end
                    end
                end
                KIND_END: begin
                    if (r_phase != PH_RUN_EMIT ||
                        r_remaining != LENGTH_WIDTH'(r_packet_count)) begin
                        n_status = ST_EARLY_END;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        o_result.out_valid  = w_valid;
        o_result.out_byte   = w_obyte;
        o_result.byte_taken = w_taken;
        o_result.done_res   = (n_status == ST_NONE) && (n_phase == PH_TAG_LO) &&
                              (n_remaining == '0);
        o_result.error_code = n_status;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_TAG_LO;
            r_tag_lo       <= '0;
            r_packet_count <= '0;
            r_run_char     <= '0;
            r_remaining    <= '0;
            r_status       <= ST_NONE;
        end else if (i_cfg_wr_en) begin
            r_phase        <= PH_TAG_LO;
            r_tag_lo       <= '0;
            r_packet_count <= '0;
            r_run_char     <= '0;
            r_remaining    <= LENGTH_WIDTH'(i_cfg_wr_data);
            r_status       <= ST_NONE;
        end else if (i_step) begin
            r_phase        <= n_phase;
            r_tag_lo       <= n_tag_lo;
            r_packet_count <= n_packet_count;
            r_run_char     <= n_run_char;
            r_remaining    <= n_remaining;
            r_status       <= n_status;
        end
    end

    a_run_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_RUN_EMIT |-> r_packet_count != '0)
        else $error("run phase with empty count");

    a_packet_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_RUN_EMIT || r_phase == PH_LITERAL) |->
        r_remaining >= LENGTH_WIDTH'(r_packet_count))
        else $error("packet longer than remaining length");

    a_taken_only_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.byte_taken |-> i_kind == KIND_BYTE)
        else $error("byte taken on non-byte item");

    a_restart_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_wr_en |=> (r_status == ST_NONE && r_phase == PH_TAG_LO))
        else $error("restart did not clear state");

endmodule

[hw/rtl/run_length_decoder_unit.sv]
// Run-length decoder.
// Input stream (s_*): tuser = kind (0 compressed byte, 1 tick, 2 end of stream),
// tdata = compressed byte. Each accepted item yields exactly one result item.
// Output stream (m_*): tuser = out_valid, tdata = out_byte, byte_taken,
// done_res, error_code. A result with byte_taken low asks the source to
// offer the same compressed byte again.
// Configuration: a pulse on i_cfg_wr_en loads expected_length and restarts
// the job; write it only while no items are in flight.
// Throughput: one item per cycle while s_tready is high; the decoder state
// updates in the accept cycle, so each item sees the state left by the one before.
// Stall: the output register is backed by a one-entry skid buffer, so one
// more item is taken while a result waits; s_tready drops once the skid
// holds an item.
// Reset: synchronous, active low; clears the job (expected_length 0, which
// reads as done) and empties the output buffers.
module run_length_decoder_unit #(
    parameter int unsigned LENGTH_WIDTH = rld_pkg::LENGTH_WIDTH_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_wr_en,
    input  logic [rld_pkg::CFG_WIDTH-1:0]        i_cfg_wr_data,
    input  logic                                 i_s_tvalid,
    output logic                                 o_s_tready,
    input  logic [rld_pkg::BYTE_WIDTH-1:0]       i_s_tdata,  // [7:0] in_byte
    input  logic [rld_pkg::KIND_WIDTH-1:0]       i_s_tuser,  // [1:0] kind
    output logic                                 o_m_tvalid,
    input  logic                                 i_m_tready,
    // [7:0] out_byte, [8] byte_taken, [9] done_res, [11:10] error_code, [15:12] zero
    output logic [rld_pkg::OUT_TDATA_WIDTH-1:0]  o_m_tdata,
    output logic                                 o_m_tuser   // [0] out_valid
);
    import rld_pkg::*;

    t_result w_result;
    logic    w_accept;
    logic    w_out_free;

    logic    r_out_valid;
    t_result r_out;
    logic    r_skid_valid;
    t_result r_skid;

    assign o_s_tready = !r_skid_valid;
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_out_free = !r_out_valid || i_m_tready;

    rld_core #(
        .LENGTH_WIDTH(LENGTH_WIDTH)
    ) u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_step        (w_accept),
        .i_kind        (t_kind'(i_s_tuser)),
        .i_byte        (i_s_tdata),
        .o_result      (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (w_out_free) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= w_accept;
            end
        end else if (w_accept) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_free) begin
            r_out <= r_skid_valid ? r_skid : w_result;
        end
        if (!w_out_free && w_accept) begin
            r_skid <= w_result;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out.out_valid;
    assign o_m_tdata  = {4'b0000, r_out.error_code, r_out.done_res,
                         r_out.byte_taken, r_out.out_byte};

endmodule
